// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted-table binary search block.
// No dependencies; imported by the sequencer and the top level.
package stbs_pkg;

  // Fixed field widths of the transaction ports.
  localparam int FIELD_W = 32;
  localparam int IDX_W   = 8;
  localparam int BOUND_W = 10;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;
  // Wide enough for range checks against any table depth below 2**17.
  localparam int WIDE_W  = 17;

  // Operation codes carried by func.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } stbs_res_t;

endpackage

// ===== rtl/sorted_table_binary_search_core.sv =====
// Top level of the sorted-table binary search block: configuration
// registers, table RAM, search sequencer and output register.
// Depends on stbs_pkg, stbs_ram and stbs_seq.
//
// Input transactions arrive on in_valid/in_stall. A write transaction stores
// entry_value at entry_index in the table and gives no result; an index at
// or beyond the table depth is ignored. A search transaction looks for
// search_key between the lower_index and upper_index registers, inclusive,
// and gives exactly one result transaction on out_valid/out_stall: found and
// the matching position (zero on a miss). A search makes at most 9 probes
// over 256 entries, none when the bounds are empty; each probe is one
// registered RAM read and one compare. in_stall stays high until the
// result moves to the output register, so a new transaction is taken while
// an earlier result waits there; a second result waits in the sequencer
// until the receiver takes the first.
// Reset (rst_n, synchronous, active low) clears the control state and sets
// the bounds to 0 and 255; the table is not cleared and must be written
// before it is searched. The user must make configuration writes only while
// idle; the block itself does not enforce it.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                cfg_we,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stbs_pkg::CFG_W-1:0]          cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [stbs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [stbs_pkg::FIELD_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::FIELD_W-1:0] in_search_key,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [stbs_pkg::IDX_W-1:0]          out_position
);

  import stbs_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [IDX_W-1:0]      lower_r, lower_nxt;
  logic [IDX_W-1:0]      upper_r, upper_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stbs_res_t             out_res_r, out_res_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  res_valid;
  logic                  res_ready;
  stbs_res_t             res;

  // Configuration register decode. Both codes of the index are in use.
  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER: lower_nxt = cfg_data;
        CFG_UPPER: upper_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '1;
    end else begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  stbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  stbs_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .lower_index    (lower_r),
    .upper_index    (upper_r),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // The output register takes a new result when it is empty or when its
  // current result is being taken in the same cycle.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_res_r.found;
  assign out_position = out_res_r.position;

endmodule

// ===== rtl/stbs_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/stbs_seq.sv =====
// Search sequencer: takes input transactions, writes the table and runs
// the probe loop against the table RAM. Depends on stbs_pkg.
module stbs_seq #(
  parameter int TABLE_DEPTH = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [stbs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [stbs_pkg::FIELD_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::FIELD_W-1:0] in_search_key,
  input  logic [stbs_pkg::IDX_W-1:0]          lower_index,
  input  logic [stbs_pkg::IDX_W-1:0]          upper_index,
  output logic                                ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_addr,
  output logic [DATA_WIDTH-1:0]               ram_wdata,
  input  logic [DATA_WIDTH-1:0]               ram_rdata,
  output logic                                res_valid,
  input  logic                                res_ready,
  output stbs_pkg::stbs_res_t                 res
);

  import stbs_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  seq_state_t                    state_r, state_nxt;
  logic signed [DATA_WIDTH-1:0]  key_r, key_nxt;
  logic signed [BOUND_W-1:0]     lo_r, lo_nxt;
  logic signed [BOUND_W-1:0]     hi_r, hi_nxt;
  logic [IDX_W-1:0]              mid_r, mid_nxt;
  stbs_res_t                     res_r, res_nxt;

  logic [IDX_W:0]                mid_sum;
  logic [IDX_W-1:0]              mid;
  logic [WIDE_W-1:0]             wr_idx_wide;
  logic [WIDE_W-1:0]             mid_wide;
  logic [WIDE_W-1:0]             mid_r_wide;
  logic                          wr_in_range;
  logic                          probe_beyond;
  logic signed [DATA_WIDTH-1:0]  probe;

  // The midpoint is only used while both bounds are non-negative.
  assign mid_sum = {1'b0, lo_r[IDX_W-1:0]} + {1'b0, hi_r[IDX_W-1:0]};
  assign mid     = mid_sum[IDX_W:1];

  assign wr_idx_wide  = WIDE_W'(in_entry_index);
  assign mid_wide     = WIDE_W'(mid);
  assign mid_r_wide   = WIDE_W'(mid_r);
  assign wr_in_range  = wr_idx_wide < WIDE_W'(TABLE_DEPTH);
  assign probe_beyond = mid_r_wide >= WIDE_W'(TABLE_DEPTH);
  assign probe        = probe_beyond ? '0 : $signed(ram_rdata);

  assign ram_wdata = DATA_WIDTH'(in_entry_value);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    res_nxt   = res_r;
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_addr  = wr_idx_wide[ADDR_W-1:0];
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_SEARCH) begin
            key_nxt   = DATA_WIDTH'(in_search_key);
            lo_nxt    = $signed(BOUND_W'(lower_index));
            hi_nxt    = $signed(BOUND_W'(upper_index));
            state_nxt = S_PROBE;
          end else begin
            ram_we = wr_in_range;
          end
        end
      end
      S_PROBE: begin
        if (lo_r > hi_r) begin
          res_nxt.found    = 1'b0;
          res_nxt.position = '0;
          state_nxt        = S_DONE;
        end else begin
          ram_addr  = mid_wide[ADDR_W-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (probe > key_r) begin
          hi_nxt    = $signed(BOUND_W'(mid_r)) - BOUND_W'(1);
          state_nxt = S_PROBE;
        end else if (probe < key_r) begin
          lo_nxt    = $signed(BOUND_W'(mid_r)) + BOUND_W'(1);
          state_nxt = S_PROBE;
        end else begin
          res_nxt.found    = 1'b1;
          res_nxt.position = mid_r;
          state_nxt        = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("table write outside idle");

  a_cmp_follows_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(state_r) == S_PROBE)
    else $error("compare without a preceding probe");

  a_lower_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> !lo_r[BOUND_W-1])
    else $error("lower bound went negative");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.found |-> res.position == '0)
    else $error("miss reported with a non-zero position");
`endif

endmodule
